>>> rtl/rpn_pkg.sv
package rpn_pkg;

	localparam int WORD_W = 32;
	localparam int STACK_DEPTH_DEF = 16;
	localparam int DIV_STEPS = WORD_W;

	localparam logic [2:0] CMD_CLEAR      = 3'd0;
	localparam logic [2:0] CMD_LITERAL    = 3'd1;
	localparam logic [2:0] CMD_SYMBOL     = 3'd2;
	localparam logic [2:0] CMD_DISALLOWED = 3'd3;
	localparam logic [2:0] CMD_UNARY      = 3'd4;
	localparam logic [2:0] CMD_BINARY     = 3'd5;
	localparam logic [2:0] CMD_TERNARY    = 3'd6;
	localparam logic [2:0] CMD_RANGE      = 3'd7;

	localparam logic [4:0] UN_PLUS = 5'd0;
	localparam logic [4:0] UN_NEG  = 5'd1;
	localparam logic [4:0] UN_LNOT = 5'd2;
	localparam logic [4:0] UN_BNOT = 5'd3;

	localparam logic [4:0] BIN_ADD  = 5'd0;
	localparam logic [4:0] BIN_SUB  = 5'd1;
	localparam logic [4:0] BIN_MUL  = 5'd2;
	localparam logic [4:0] BIN_DIV  = 5'd3;
	localparam logic [4:0] BIN_MOD  = 5'd4;
	localparam logic [4:0] BIN_POW  = 5'd5;
	localparam logic [4:0] BIN_SHL  = 5'd6;
	localparam logic [4:0] BIN_SHR  = 5'd7;
	localparam logic [4:0] BIN_LT   = 5'd8;
	localparam logic [4:0] BIN_LE   = 5'd9;
	localparam logic [4:0] BIN_GT   = 5'd10;
	localparam logic [4:0] BIN_GE   = 5'd11;
	localparam logic [4:0] BIN_EQ   = 5'd12;
	localparam logic [4:0] BIN_NE   = 5'd13;
	localparam logic [4:0] BIN_AND  = 5'd14;
	localparam logic [4:0] BIN_XOR  = 5'd15;
	localparam logic [4:0] BIN_OR   = 5'd16;
	localparam logic [4:0] BIN_LAND = 5'd17;
	localparam logic [4:0] BIN_LOR  = 5'd18;
	localparam logic [4:0] BIN_LXOR = 5'd19;

	localparam logic [4:0] RNG_MEM = 5'd0;
	localparam logic [4:0] RNG_S8  = 5'd1;
	localparam logic [4:0] RNG_S16 = 5'd2;
	localparam logic [4:0] RNG_U8  = 5'd3;
	localparam logic [4:0] RNG_U16 = 5'd4;

	localparam logic signed [WORD_W-1:0] S8_MIN  = -32'sd128;
	localparam logic signed [WORD_W-1:0] S8_MAX  = 32'sd127;
	localparam logic signed [WORD_W-1:0] S16_MIN = -32'sd32768;
	localparam logic signed [WORD_W-1:0] S16_MAX = 32'sd32767;
	localparam logic signed [WORD_W-1:0] U8_MAX  = 32'sd255;
	localparam logic signed [WORD_W-1:0] U16_MAX = 32'sd65535;

	localparam logic [3:0] ERR_NONE       = 4'd0;
	localparam logic [3:0] ERR_UNDEFINED  = 4'd1;
	localparam logic [3:0] ERR_DISALLOWED = 4'd2;
	localparam logic [3:0] ERR_DIV0       = 4'd3;
	localparam logic [3:0] ERR_MOD0       = 4'd4;
	localparam logic [3:0] ERR_NEGEXP     = 4'd5;
	localparam logic [3:0] ERR_ZPOWZ      = 4'd6;
	localparam logic [3:0] ERR_UNDERFLOW  = 4'd7;
	localparam logic [3:0] ERR_OVERFLOW   = 4'd8;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD,
		DP_RD_Y,
		DP_RD_Z,
		DP_MUL,
		DP_DIV_INIT,
		DP_DIV_STEP,
		DP_POW_INIT,
		DP_POW_R,
		DP_POW_B,
		DP_EXEC,
		DP_COMMIT
	} dp_op_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic [4:0] op;
		logic       operands_ok;
		logic       x_zero;
		logic       x_neg;
		logic       div_last;
		logic       pow_done;
	} dp_status_t;

endpackage

>>> rtl/rpn_ctrl.sv
module rpn_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  rpn_pkg::dp_status_t status,
	output rpn_pkg::dp_op_t     dp_op
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_RD_Y,
		S_RD_Z,
		S_MUL,
		S_DIV_INIT,
		S_DIV_STEP,
		S_POW_INIT,
		S_POW_R,
		S_POW_B,
		S_EXEC,
		S_COMMIT
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		dp_op   = rpn_pkg::DP_NOP;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					dp_op   = rpn_pkg::DP_LOAD;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (status.operands_ok && (status.cmd == rpn_pkg::CMD_BINARY ||
						status.cmd == rpn_pkg::CMD_TERNARY)) begin
					state_d = S_RD_Y;
				end else begin
					state_d = S_EXEC;
				end
			end
			S_RD_Y: begin
				dp_op = rpn_pkg::DP_RD_Y;
				if (status.cmd == rpn_pkg::CMD_TERNARY) begin
					state_d = S_RD_Z;
				end else begin
					case (status.op)
						rpn_pkg::BIN_MUL: state_d = S_MUL;
						rpn_pkg::BIN_DIV, rpn_pkg::BIN_MOD:
							state_d = status.x_zero ? S_EXEC : S_DIV_INIT;
						rpn_pkg::BIN_POW: state_d = status.x_neg ? S_EXEC : S_POW_INIT;
						default: state_d = S_EXEC;
					endcase
				end
			end
			S_RD_Z: begin
				dp_op   = rpn_pkg::DP_RD_Z;
				state_d = S_EXEC;
			end
			S_MUL: begin
				dp_op   = rpn_pkg::DP_MUL;
				state_d = S_EXEC;
			end
			S_DIV_INIT: begin
				dp_op   = rpn_pkg::DP_DIV_INIT;
				state_d = S_DIV_STEP;
			end
			S_DIV_STEP: begin
				dp_op = rpn_pkg::DP_DIV_STEP;
				if (status.div_last) begin
					state_d = S_EXEC;
				end
			end
			S_POW_INIT: begin
				dp_op   = rpn_pkg::DP_POW_INIT;
				state_d = S_POW_R;
			end
			S_POW_R: begin
				if (status.pow_done) begin
					state_d = S_EXEC;
				end else begin
					dp_op   = rpn_pkg::DP_POW_R;
					state_d = S_POW_B;
				end
			end
			S_POW_B: begin
				dp_op   = rpn_pkg::DP_POW_B;
				state_d = S_POW_R;
			end
			S_EXEC: begin
				dp_op   = rpn_pkg::DP_EXEC;
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				if (out_free) begin
					dp_op   = rpn_pkg::DP_COMMIT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_COMMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_accept_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_DECODE))
		else $error("accepted request did not enter decode");

	a_result_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_COMMIT))
		else $error("result raised outside commit");

	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV_STEP && !status.div_last) |=> (state_q == S_DIV_STEP))
		else $error("division left early");

	a_commit_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMMIT && out_valid_q && out_stall) |=> (state_q == S_COMMIT))
		else $error("result overwritten while stalled");

endmodule

>>> rtl/rpn_dp.sv
module rpn_dp #(
	parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF,
	localparam int LW = $clog2(STACK_DEPTH + 1),
	localparam int AW = $clog2(STACK_DEPTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data,
	input  rpn_pkg::dp_op_t     dp_op,
	output rpn_pkg::dp_status_t status,
	input  logic [2:0]          cmd,
	input  logic [4:0]          op_code,
	input  logic signed [31:0]  operand_value,
	input  logic                symbol_found,
	output logic signed [31:0]  top_value,
	output logic [LW-1:0]       stack_depth,
	output logic [3:0]          error_code,
	output logic                range_warning
);

	localparam int W = rpn_pkg::WORD_W;

	logic [W-1:0] mem [STACK_DEPTH];

	logic          undef_zero_q;
	logic [LW-1:0] level_q;
	logic [2:0]    cmd_q;
	logic [4:0]    op_q;
	logic [W-1:0]  val_q;
	logic          found_q;
	logic [W-1:0]  tos_q, y_q, z_q;
	logic [W-1:0]  pr_q, pb_q, pe_q;
	logic [W-1:0]  rem_q, quo_q, dvs_q;
	logic [4:0]    cnt_q;
	logic [W-1:0]  res_q;
	logic [3:0]    err_q;
	logic          warn_q, upd_q;
	logic [W-1:0]  out_top_q;
	logic [LW-1:0] out_lvl_q;
	logic [3:0]    out_err_q;
	logic          out_warn_q;

	logic [W-1:0]  mul_a, mul_b, mul_p;
	logic [W:0]    rem_sh, diff;
	logic [W-1:0]  quot, remd;
	logic          full, ops_ok;
	logic [W-1:0]  ex_res;
	logic [3:0]    ex_err;
	logic          ex_warn, ex_upd;
	logic [LW-1:0] nxt_lvl;
	logic [W-1:0]  nxt_tos;
	logic signed [W-1:0] xs, ys;

	assign xs   = $signed(tos_q);
	assign ys   = $signed(y_q);
	assign full = (level_q == LW'(STACK_DEPTH));

	always_comb begin
		case (cmd_q)
			rpn_pkg::CMD_UNARY, rpn_pkg::CMD_RANGE: ops_ok = (level_q >= LW'(1));
			rpn_pkg::CMD_BINARY:  ops_ok = (level_q >= LW'(2));
			rpn_pkg::CMD_TERNARY: ops_ok = (level_q >= LW'(3));
			default: ops_ok = 1'b1;
		endcase
	end

	assign status.cmd         = cmd_q;
	assign status.op          = op_q;
	assign status.operands_ok = ops_ok;
	assign status.x_zero      = (tos_q == '0);
	assign status.x_neg       = tos_q[W-1];
	assign status.div_last    = (cnt_q == 5'(rpn_pkg::DIV_STEPS - 1));
	assign status.pow_done    = (pe_q == '0);

	always_comb begin
		case (dp_op)
			rpn_pkg::DP_POW_R: begin
				mul_a = pr_q;
				mul_b = pb_q;
			end
			rpn_pkg::DP_POW_B: begin
				mul_a = pb_q;
				mul_b = pb_q;
			end
			default: begin
				mul_a = y_q;
				mul_b = tos_q;
			end
		endcase
	end
	assign mul_p = W'(mul_a * mul_b);

	assign rem_sh = {rem_q, quo_q[W-1]};
	assign diff   = rem_sh - {1'b0, dvs_q};
	assign quot   = (y_q[W-1] ^ tos_q[W-1]) ? (W'(0) - quo_q) : quo_q;
	assign remd   = y_q[W-1] ? (W'(0) - rem_q) : rem_q;

	always_comb begin
		ex_res  = '0;
		ex_err  = rpn_pkg::ERR_NONE;
		ex_warn = 1'b0;
		ex_upd  = 1'b0;
		case (cmd_q)
			rpn_pkg::CMD_CLEAR: ex_upd = 1'b1;
			rpn_pkg::CMD_LITERAL, rpn_pkg::CMD_SYMBOL, rpn_pkg::CMD_DISALLOWED: begin
				if (full) begin
					ex_err = rpn_pkg::ERR_OVERFLOW;
				end else begin
					ex_upd = 1'b1;
					if (cmd_q == rpn_pkg::CMD_LITERAL) begin
						ex_res = val_q;
					end else if (cmd_q == rpn_pkg::CMD_SYMBOL) begin
						if (found_q) begin
							ex_res = val_q;
						end else if (!undef_zero_q) begin
							ex_err = rpn_pkg::ERR_UNDEFINED;
						end
					end else begin
						ex_err = rpn_pkg::ERR_DISALLOWED;
					end
				end
			end
			default: begin
				if (!ops_ok) begin
					ex_err = rpn_pkg::ERR_UNDERFLOW;
				end else begin
					ex_upd = (cmd_q != rpn_pkg::CMD_RANGE);
					case (cmd_q)
						rpn_pkg::CMD_UNARY: begin
							case (op_q)
								rpn_pkg::UN_PLUS: ex_res = tos_q;
								rpn_pkg::UN_NEG:  ex_res = W'(0) - tos_q;
								rpn_pkg::UN_LNOT: ex_res = W'(tos_q == '0);
								rpn_pkg::UN_BNOT: ex_res = ~tos_q;
								default:          ex_res = '0;
							endcase
						end
						rpn_pkg::CMD_BINARY: begin
							case (op_q)
								rpn_pkg::BIN_ADD: ex_res = y_q + tos_q;
								rpn_pkg::BIN_SUB: ex_res = y_q - tos_q;
								rpn_pkg::BIN_MUL: ex_res = pr_q;
								rpn_pkg::BIN_DIV: begin
									if (tos_q == '0) begin
										ex_err = rpn_pkg::ERR_DIV0;
									end else begin
										ex_res = quot;
									end
								end
								rpn_pkg::BIN_MOD: begin
									if (tos_q == '0) begin
										ex_err = rpn_pkg::ERR_MOD0;
									end else begin
										ex_res = remd;
									end
								end
								rpn_pkg::BIN_POW: begin
									if (tos_q[W-1]) begin
										ex_err = rpn_pkg::ERR_NEGEXP;
									end else if (y_q == '0 && tos_q == '0) begin
										ex_err = rpn_pkg::ERR_ZPOWZ;
										ex_res = W'(1);
									end else begin
										ex_res = pr_q;
									end
								end
								rpn_pkg::BIN_SHL:
									ex_res = (tos_q[W-1:5] != '0) ? '0 : (y_q << tos_q[4:0]);
								rpn_pkg::BIN_SHR:
									ex_res = (tos_q[W-1:5] != '0) ? {W{y_q[W-1]}} :
										W'(ys >>> tos_q[4:0]);
								rpn_pkg::BIN_LT:   ex_res = W'(ys < xs);
								rpn_pkg::BIN_LE:   ex_res = W'(ys <= xs);
								rpn_pkg::BIN_GT:   ex_res = W'(ys > xs);
								rpn_pkg::BIN_GE:   ex_res = W'(ys >= xs);
								rpn_pkg::BIN_EQ:   ex_res = W'(y_q == tos_q);
								rpn_pkg::BIN_NE:   ex_res = W'(y_q != tos_q);
								rpn_pkg::BIN_AND:  ex_res = y_q & tos_q;
								rpn_pkg::BIN_XOR:  ex_res = y_q ^ tos_q;
								rpn_pkg::BIN_OR:   ex_res = y_q | tos_q;
								rpn_pkg::BIN_LAND: ex_res = W'((y_q != '0) && (tos_q != '0));
								rpn_pkg::BIN_LOR:  ex_res = W'((y_q != '0) || (tos_q != '0));
								rpn_pkg::BIN_LXOR: ex_res = W'((y_q != '0) ^ (tos_q != '0));
								default:           ex_res = '0;
							endcase
						end
						rpn_pkg::CMD_TERNARY: ex_res = (z_q != '0) ? y_q : tos_q;
						default: begin
							case (op_q)
								rpn_pkg::RNG_MEM: ex_warn = (xs < 0);
								rpn_pkg::RNG_S8:
									ex_warn = (xs < rpn_pkg::S8_MIN) || (xs > rpn_pkg::S8_MAX);
								rpn_pkg::RNG_S16:
									ex_warn = (xs < rpn_pkg::S16_MIN) || (xs > rpn_pkg::S16_MAX);
								rpn_pkg::RNG_U8:
									ex_warn = (xs < 0) || (xs > rpn_pkg::U8_MAX);
								rpn_pkg::RNG_U16:
									ex_warn = (xs < 0) || (xs > rpn_pkg::U16_MAX);
								default: ex_warn = 1'b0;
							endcase
						end
					endcase
				end
			end
		endcase
	end

	always_comb begin
		nxt_lvl = level_q;
		nxt_tos = tos_q;
		if (upd_q) begin
			case (cmd_q)
				rpn_pkg::CMD_CLEAR: nxt_lvl = '0;
				rpn_pkg::CMD_LITERAL, rpn_pkg::CMD_SYMBOL, rpn_pkg::CMD_DISALLOWED: begin
					nxt_lvl = level_q + LW'(1);
					nxt_tos = res_q;
				end
				rpn_pkg::CMD_UNARY: nxt_tos = res_q;
				rpn_pkg::CMD_BINARY: begin
					nxt_lvl = level_q - LW'(1);
					nxt_tos = res_q;
				end
				rpn_pkg::CMD_TERNARY: begin
					nxt_lvl = level_q - LW'(2);
					nxt_tos = res_q;
				end
				default: nxt_lvl = level_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			undef_zero_q <= 1'b0;
			level_q      <= '0;
		end else begin
			if (cfg_wr_en) begin
				undef_zero_q <= cfg_wr_data;
			end
			if (dp_op == rpn_pkg::DP_COMMIT) begin
				level_q <= nxt_lvl;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (dp_op)
			rpn_pkg::DP_LOAD: begin
				cmd_q   <= cmd;
				op_q    <= op_code;
				val_q   <= operand_value;
				found_q <= symbol_found;
			end
			rpn_pkg::DP_RD_Y: y_q <= mem[AW'(level_q - LW'(2))];
			rpn_pkg::DP_RD_Z: z_q <= mem[AW'(level_q - LW'(3))];
			rpn_pkg::DP_MUL:  pr_q <= mul_p;
			rpn_pkg::DP_DIV_INIT: begin
				rem_q <= '0;
				quo_q <= y_q[W-1] ? (W'(0) - y_q) : y_q;
				dvs_q <= tos_q[W-1] ? (W'(0) - tos_q) : tos_q;
				cnt_q <= '0;
			end
			rpn_pkg::DP_DIV_STEP: begin
				cnt_q <= cnt_q + 5'd1;
				if (!diff[W]) begin
					rem_q <= diff[W-1:0];
					quo_q <= {quo_q[W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[W-1:0];
					quo_q <= {quo_q[W-2:0], 1'b0};
				end
			end
			rpn_pkg::DP_POW_INIT: begin
				pr_q <= W'(1);
				pb_q <= y_q;
				pe_q <= tos_q;
			end
			rpn_pkg::DP_POW_R: begin
				if (pe_q[0]) begin
					pr_q <= mul_p;
				end
			end
			rpn_pkg::DP_POW_B: begin
				pb_q <= mul_p;
				pe_q <= pe_q >> 1;
			end
			rpn_pkg::DP_EXEC: begin
				res_q  <= ex_res;
				err_q  <= ex_err;
				warn_q <= ex_warn;
				upd_q  <= ex_upd;
			end
			rpn_pkg::DP_COMMIT: begin
				tos_q      <= nxt_tos;
				out_top_q  <= (nxt_lvl != '0) ? nxt_tos : '0;
				out_lvl_q  <= nxt_lvl;
				out_err_q  <= err_q;
				out_warn_q <= warn_q;
				if (upd_q && level_q != '0 && (cmd_q == rpn_pkg::CMD_LITERAL ||
						cmd_q == rpn_pkg::CMD_SYMBOL || cmd_q == rpn_pkg::CMD_DISALLOWED)) begin
					mem[AW'(level_q - LW'(1))] <= tos_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign top_value     = $signed(out_top_q);
	assign stack_depth   = out_lvl_q;
	assign error_code    = out_err_q;
	assign range_warning = out_warn_q;

endmodule

>>> rtl/rpn_integer_stack_evaluator.sv
// Postfix integer evaluator on an operand stack of STACK_DEPTH 32-bit entries.
// A request on the input channel (in_valid, in_stall, cmd, op_code, operand_value,
// symbol_found) is accepted when in_valid is high and in_stall is low; in_stall
// is high from acceptance until the result has been placed in the output register.
// Every request yields exactly one result on the output channel (out_valid,
// out_stall, top_value, stack_depth, error_code, range_warning), taken when
// out_valid is high and out_stall is low.
// Binary and ternary requests with enough operands read the lower ones from memory;
// divide and modulo run one radix-2 step a cycle, and power uses square and multiply
// on one shared multiplier, which multiply uses too. A new request is accepted
// in the cycle after the previous result is registered, even while that result waits.
// If the receiver stalls, the next result is held back until the output register
// frees. The top of stack is kept in a register; the entries below it live in a
// memory read one word per cycle. Reset empties the stack and clears the
// undefined_as_zero register; the memory itself is not cleared.
module rpn_integer_stack_evaluator #(
	parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF,
	localparam int LW = $clog2(STACK_DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic               cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         cmd,
	input  logic [4:0]         op_code,
	input  logic signed [31:0] operand_value,
	input  logic               symbol_found,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] top_value,
	output logic [LW-1:0]      stack_depth,
	output logic [3:0]         error_code,
	output logic               range_warning
);

	rpn_pkg::dp_status_t status;
	rpn_pkg::dp_op_t     dp_op;

	rpn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.dp_op     (dp_op)
	);

	rpn_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.dp_op         (dp_op),
		.status        (status),
		.cmd           (cmd),
		.op_code       (op_code),
		.operand_value (operand_value),
		.symbol_found  (symbol_found),
		.top_value     (top_value),
		.stack_depth   (stack_depth),
		.error_code    (error_code),
		.range_warning (range_warning)
	);

endmodule

>>> tb/rpn_integer_stack_evaluator_tb.sv
module rpn_integer_stack_evaluator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 16;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct {
		logic [2:0]  cmd;
		logic [4:0]  op;
		logic [31:0] val;
		logic        found;
	} rpn_request_t;

	typedef struct {
		logic [31:0] top;
		logic [4:0]  depth;
		logic [3:0]  err;
		logic        warn;
	} rpn_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic cfg_wr_data = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] cmd = '0;
	logic [4:0] op_code = '0;
	logic signed [31:0] operand_value = '0;
	logic symbol_found = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] top_value;
	logic [4:0] stack_depth;
	logic [3:0] error_code;
	logic range_warning;

	rpn_integer_stack_evaluator #(.STACK_DEPTH(DEPTH)) u_top (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .op_code(op_code),
		.operand_value(operand_value), .symbol_found(symbol_found),
		.out_valid(out_valid), .out_stall(out_stall), .top_value(top_value),
		.stack_depth(stack_depth), .error_code(error_code), .range_warning(range_warning)
	);

	rpn_request_t pending_requests[$];
	rpn_result_t expected_results[$];
	rpn_request_t cur_request;
	logic [31:0] model_stack[DEPTH];
	int model_level = 0;
	logic model_uaz = 1'b0;
	int gen_level = 0;
	int mismatches = 0;
	int results_seen = 0;
	int send_gap = 0;
	int recv_cnt = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	bit quiet = 1'b0;
	int cycles = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [31:0] power_of(logic [31:0] base, logic [31:0] ex,
			inout logic [3:0] err);
		logic [31:0] r;
		logic [31:0] b;
		r = 1;
		b = base;
		if (ex[31]) begin
			err = rpn_pkg::ERR_NEGEXP;
			return 0;
		end
		if (base == 0 && ex == 0) begin
			err = rpn_pkg::ERR_ZPOWZ;
			return 1;
		end
		while (ex != 0) begin
			if (ex[0]) r = r * b;
			b = b * b;
			ex = ex >> 1;
		end
		return r;
	endfunction

	function automatic logic [31:0] binary_of(logic [4:0] op, logic [31:0] l, logic [31:0] r,
			inout logic [3:0] err);
		logic signed [31:0] sl;
		logic signed [31:0] sr;
		sl = l;
		sr = r;
		case (op)
			rpn_pkg::BIN_ADD: return l + r;
			rpn_pkg::BIN_SUB: return l - r;
			rpn_pkg::BIN_MUL: return l * r;
			rpn_pkg::BIN_DIV: begin
				if (r == 0) begin
					err = rpn_pkg::ERR_DIV0;
					return 0;
				end
				if (l == 32'h8000_0000 && r == 32'hFFFF_FFFF) return l;
				return sl / sr;
			end
			rpn_pkg::BIN_MOD: begin
				if (r == 0) begin
					err = rpn_pkg::ERR_MOD0;
					return 0;
				end
				if (l == 32'h8000_0000 && r == 32'hFFFF_FFFF) return 0;
				return sl % sr;
			end
			rpn_pkg::BIN_POW: return power_of(l, r, err);
			rpn_pkg::BIN_SHL: return (sr < 0 || sr > 31) ? 32'd0 : l << r[4:0];
			rpn_pkg::BIN_SHR: begin
				if (sr < 0 || sr > 31) return {32{l[31]}};
				return sl >>> r[4:0];
			end
			rpn_pkg::BIN_LT: return {31'd0, sl < sr};
			rpn_pkg::BIN_LE: return {31'd0, sl <= sr};
			rpn_pkg::BIN_GT: return {31'd0, sl > sr};
			rpn_pkg::BIN_GE: return {31'd0, sl >= sr};
			rpn_pkg::BIN_EQ: return {31'd0, l == r};
			rpn_pkg::BIN_NE: return {31'd0, l != r};
			rpn_pkg::BIN_AND: return l & r;
			rpn_pkg::BIN_XOR: return l ^ r;
			rpn_pkg::BIN_OR: return l | r;
			rpn_pkg::BIN_LAND: return {31'd0, (l != 0) && (r != 0)};
			rpn_pkg::BIN_LOR: return {31'd0, (l != 0) || (r != 0)};
			rpn_pkg::BIN_LXOR: return {31'd0, (l != 0) ^ (r != 0)};
			default: return 0;
		endcase
	endfunction

	function automatic logic out_of_range(logic [4:0] kind, logic signed [31:0] v);
		case (kind)
			rpn_pkg::RNG_MEM: return v < 0;
			rpn_pkg::RNG_S8: return v < rpn_pkg::S8_MIN || v > rpn_pkg::S8_MAX;
			rpn_pkg::RNG_S16: return v < rpn_pkg::S16_MIN || v > rpn_pkg::S16_MAX;
			rpn_pkg::RNG_U8: return v < 0 || v > rpn_pkg::U8_MAX;
			rpn_pkg::RNG_U16: return v < 0 || v > rpn_pkg::U16_MAX;
			default: return 1'b0;
		endcase
	endfunction

	function automatic rpn_result_t evaluate(rpn_request_t q);
		rpn_result_t e;
		int need;
		int t;
		logic [31:0] x;
		logic [31:0] res;
		e.err = rpn_pkg::ERR_NONE;
		e.warn = 1'b0;
		res = 0;
		case (q.cmd)
			rpn_pkg::CMD_CLEAR: model_level = 0;
			rpn_pkg::CMD_LITERAL, rpn_pkg::CMD_SYMBOL, rpn_pkg::CMD_DISALLOWED: begin
				if (model_level >= DEPTH) begin
					e.err = rpn_pkg::ERR_OVERFLOW;
				end else begin
					if (q.cmd == rpn_pkg::CMD_LITERAL) begin
						res = q.val;
					end else if (q.cmd == rpn_pkg::CMD_SYMBOL) begin
						if (q.found) res = q.val;
						else if (!model_uaz) e.err = rpn_pkg::ERR_UNDEFINED;
					end else begin
						e.err = rpn_pkg::ERR_DISALLOWED;
					end
					model_stack[model_level] = res;
					model_level++;
				end
			end
			default: begin
				need = (q.cmd == rpn_pkg::CMD_UNARY || q.cmd == rpn_pkg::CMD_RANGE) ? 1 :
					(q.cmd == rpn_pkg::CMD_BINARY ? 2 : 3);
				if (model_level < need) begin
					e.err = rpn_pkg::ERR_UNDERFLOW;
				end else begin
					t = model_level - 1;
					x = model_stack[t];
					if (q.cmd == rpn_pkg::CMD_UNARY) begin
						case (q.op)
							rpn_pkg::UN_PLUS: res = x;
							rpn_pkg::UN_NEG: res = -x;
							rpn_pkg::UN_LNOT: res = {31'd0, x == 0};
							rpn_pkg::UN_BNOT: res = ~x;
							default: res = 0;
						endcase
						model_stack[t] = res;
					end else if (q.cmd == rpn_pkg::CMD_BINARY) begin
						model_stack[t-1] = binary_of(q.op, model_stack[t-1], x, e.err);
						model_level = t;
					end else if (q.cmd == rpn_pkg::CMD_TERNARY) begin
						model_stack[t-2] = (model_stack[t-2] != 0) ? model_stack[t-1] : x;
						model_level = t - 1;
					end else begin
						e.warn = out_of_range(q.op, x);
					end
				end
			end
		endcase
		e.top = model_level != 0 ? model_stack[model_level-1] : 32'd0;
		e.depth = model_level[4:0];
		return e;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at result %0d: %s got %0d expected %0d", results_seen, what,
			$signed(got), $signed(want));
		mismatches++;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_results.insert(expected_results.size(), evaluate(cur_request));
			if (in_valid && in_stall) begin
			end else if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_requests.size() > 0) begin
				cur_request = pending_requests.pop_front();
				cmd <= cur_request.cmd;
				op_code <= cur_request.op;
				operand_value <= cur_request.val;
				symbol_found <= cur_request.found;
				in_valid <= 1'b1;
				send_gap <= pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		rpn_result_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					report_mismatch("result with no request waiting", top_value, 32'd0);
				end else begin
					e = expected_results.pop_front();
					if (top_value !== e.top) report_mismatch("top_value", top_value, e.top);
					if (stack_depth !== e.depth)
						report_mismatch("stack_depth", 32'(stack_depth), 32'(e.depth));
					if (error_code !== e.err)
						report_mismatch("error_code", 32'(error_code), 32'(e.err));
					if (range_warning !== e.warn)
						report_mismatch("range_warning", 32'(range_warning), 32'(e.warn));
				end
			end
			if (!hold_done && results_seen >= 200) begin
				hold_done <= 1'b1;
				hold_left <= 400;
				out_stall <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else if (quiet) begin
				out_stall <= 1'b0;
			end else if (recv_cnt > 0) begin
				recv_cnt <= recv_cnt - 1;
			end else begin
				out_stall <= $urandom_range(0, 2) == 0;
				recv_cnt <= pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("rpn_integer_stack_evaluator_tb failed");
			$finish;
		end
	end

	task automatic add_request(logic [2:0] c, logic [4:0] op, logic [31:0] v, logic f);
		rpn_request_t q;
		q.cmd = c;
		q.op = op;
		q.val = v;
		q.found = f;
		pending_requests.insert(pending_requests.size(), q);
		case (c)
			rpn_pkg::CMD_CLEAR: gen_level = 0;
			rpn_pkg::CMD_LITERAL, rpn_pkg::CMD_SYMBOL, rpn_pkg::CMD_DISALLOWED:
				if (gen_level < DEPTH) gen_level++;
			rpn_pkg::CMD_BINARY: if (gen_level >= 2) gen_level--;
			rpn_pkg::CMD_TERNARY: if (gen_level >= 3) gen_level -= 2;
			default: ;
		endcase
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 0;
			3: return 32'hFFFF_FFFF;
			4, 5: return $urandom_range(0, 40);
			6: return -$urandom_range(1, 300);
			7: return $urandom_range(0, 70000);
			default: return $urandom;
		endcase
	endfunction

	task automatic add_random(output int n);
		int r;
		int k;
		r = $urandom_range(0, 99);
		n = 1;
		if (r < 3) begin
			add_request(rpn_pkg::CMD_CLEAR, 5'($urandom), $urandom, 1'($urandom));
		end else if (r < 8) begin
			add_request(3'($urandom), 5'($urandom), $urandom, 1'($urandom));
		end else if (r < 10) begin
			n = DEPTH + 1 - gen_level;
			for (k = 0; k < n; k++)
				add_request(rpn_pkg::CMD_LITERAL, 5'($urandom), pick_value(), 1'($urandom));
		end else if (gen_level < 2 || r < 40) begin
			k = $urandom_range(0, 9);
			if (k < 7)
				add_request(rpn_pkg::CMD_LITERAL, 5'($urandom), pick_value(), 1'($urandom));
			else if (k < 9)
				add_request(rpn_pkg::CMD_SYMBOL, 5'($urandom), pick_value(), 1'($urandom));
			else
				add_request(rpn_pkg::CMD_DISALLOWED, 5'($urandom), $urandom, 1'($urandom));
		end else if (r < 52) begin
			add_request(rpn_pkg::CMD_UNARY,
				5'(r < 50 ? $urandom_range(0, 3) : $urandom), 0, 0);
		end else if (r < 82) begin
			add_request(rpn_pkg::CMD_BINARY,
				5'(r < 80 ? $urandom_range(0, 19) : $urandom), 0, 0);
		end else if (r < 90 && gen_level >= 3) begin
			add_request(rpn_pkg::CMD_TERNARY, 5'($urandom), $urandom, 1'($urandom));
		end else begin
			add_request(rpn_pkg::CMD_RANGE,
				5'(r < 98 ? $urandom_range(0, 4) : $urandom), 0, 0);
		end
	endtask

	task automatic drain();
		do @(negedge clk);
		while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (80) @(negedge clk);
	endtask

	initial begin
		int phase;
		int sent;
		int n;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		add_request(rpn_pkg::CMD_UNARY, rpn_pkg::UN_NEG, 0, 0);
		add_request(rpn_pkg::CMD_BINARY, rpn_pkg::BIN_ADD, 0, 0);
		add_request(rpn_pkg::CMD_LITERAL, 0, 32'h8000_0000, 0);
		add_request(rpn_pkg::CMD_LITERAL, 0, 32'hFFFF_FFFF, 0);
		add_request(rpn_pkg::CMD_BINARY, rpn_pkg::BIN_DIV, 0, 0);
		add_request(rpn_pkg::CMD_LITERAL, 0, 32'hFFFF_FFFF, 0);
		add_request(rpn_pkg::CMD_BINARY, rpn_pkg::BIN_MOD, 0, 0);
		add_request(rpn_pkg::CMD_LITERAL, 0, 0, 0);
		add_request(rpn_pkg::CMD_BINARY, rpn_pkg::BIN_DIV, 0, 0);
		add_request(rpn_pkg::CMD_LITERAL, 0, 0, 0);
		add_request(rpn_pkg::CMD_BINARY, rpn_pkg::BIN_MOD, 0, 0);
		add_request(rpn_pkg::CMD_LITERAL, 0, 0, 0);
		add_request(rpn_pkg::CMD_BINARY, rpn_pkg::BIN_POW, 0, 0);
		add_request(rpn_pkg::CMD_LITERAL, 0, 32'hFFFF_FFFF, 0);
		add_request(rpn_pkg::CMD_BINARY, rpn_pkg::BIN_POW, 0, 0);
		add_request(rpn_pkg::CMD_LITERAL, 0, 32'h8000_0000, 0);
		add_request(rpn_pkg::CMD_LITERAL, 0, 40, 0);
		add_request(rpn_pkg::CMD_BINARY, rpn_pkg::BIN_SHR, 0, 0);
		add_request(rpn_pkg::CMD_RANGE, rpn_pkg::RNG_S8, 0, 0);
		add_request(rpn_pkg::CMD_LITERAL, 0, 32'h7FFF_FFFF, 0);
		add_request(rpn_pkg::CMD_TERNARY, 0, 0, 0);
		add_request(rpn_pkg::CMD_UNARY, 5'd31, 0, 0);
		add_request(rpn_pkg::CMD_SYMBOL, 0, 32'h1234_5678, 0);
		add_request(rpn_pkg::CMD_SYMBOL, 0, 32'h8765_4321, 1);
		add_request(rpn_pkg::CMD_DISALLOWED, 0, 0, 0);
		drain();
		for (phase = 0; phase < 5; phase++) begin
			if (phase > 0) begin
				@(posedge clk);
				cfg_wr_en <= 1'b1;
				cfg_wr_data <= phase[0];
				@(posedge clk);
				cfg_wr_en <= 1'b0;
				model_uaz = phase[0];
			end
			quiet = (phase == 3);
			sent = 0;
			while (sent < 105) begin
				add_random(n);
				sent += n;
			end
			drain();
		end
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("rpn_integer_stack_evaluator_tb passed");
		end else begin
			$display("rpn_integer_stack_evaluator_tb failed");
		end
		$finish;
	end

endmodule
